// File: src/dcf_pkg.sv
package dcf_pkg;

  // Framing characters
  localparam logic [7:0] CHR_SLASH = 8'h2F;
  localparam logic [7:0] CHR_NL    = 8'h0A;
  localparam logic [7:0] CHR_GT    = 8'h3E;
  localparam logic [7:0] CHR_SP    = 8'h20;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;

  // Binary frame fields
  localparam logic [7:0] SPEED_LEN_FIELD = 8'h04;
  localparam logic [7:0] SPEED_CMD       = 8'h86;
  localparam logic [7:0] STOP_CMD        = 8'hFF;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam int          NUM_DIGITS = 5;
  localparam int          STR_MAX    = NUM_DIGITS + 1;

  // Per-lane result handed to the framer
  typedef struct packed {
    logic                     neg;
    logic [15:0]              bin;
    logic [STR_MAX-1:0][7:0]  str;
    logic [2:0]               len;
  } dcf_lane_res_t;

  // Decimal weight of each digit position, most significant first
  function automatic logic [13:0] pow10(input logic [2:0] pos);
    logic [13:0] w;
    unique case (pos)
      3'd0:    w = 14'd10000;
      3'd1:    w = 14'd1000;
      3'd2:    w = 14'd100;
      3'd3:    w = 14'd10;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

  // CRC-16, MSB first, one byte folded in
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int j = 0; j < 8; j++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: src/dcf_lane.sv
module dcf_lane
  import dcf_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  logic          take_i,
  input  logic [15:0]   raw_i,
  input  logic [14:0]   limit_i,
  output logic          done_o,
  output dcf_lane_res_t res_o
);

  logic        busy_q, busy_d;
  logic        vld_q, vld_d;
  logic [2:0]  step_q, step_d;
  logic        neg_q;
  logic [15:0] bin_q;
  logic [14:0] mag_q, mag_d;
  logic [3:0]  dig_q [NUM_DIGITS];

  logic signed [16:0] val, lim, clamped;
  logic [14:0]        mag_ld;
  logic [13:0]        weight;
  logic [16:0]        mult [10];
  logic [3:0]         digit;

  // Symmetric clamp of the incoming value
  always_comb begin
    val = {raw_i[15], raw_i};
    lim = {2'b00, limit_i};
    if (val > lim) begin
      clamped = lim;
    end else if (val < -lim) begin
      clamped = -lim;
    end else begin
      clamped = val;
    end
    mag_ld = clamped[16] ? 15'(-clamped) : clamped[14:0];
  end

  // One decimal digit per cycle by compare against multiples of the weight
  always_comb begin
    weight = pow10(step_q);
    digit  = 4'd0;
    for (int k = 0; k < 10; k++) begin
      mult[k] = 17'(k) * {3'b000, weight};
    end
    for (int k = 1; k < 10; k++) begin
      if ({2'b00, mag_q} >= mult[k]) begin
        digit = 4'(k);
      end
    end
    mag_d = mag_q - mult[digit][14:0];
  end

  // Control
  always_comb begin
    busy_d = busy_q;
    vld_d  = vld_q;
    step_d = step_q;
    if (busy_q) begin
      step_d = step_q + 3'd1;
      if (step_q == 3'(NUM_DIGITS - 1)) begin
        busy_d = 1'b0;
      end
    end
    if (take_i) begin
      vld_d = 1'b0;
    end
    if (load_i) begin
      busy_d = 1'b1;
      vld_d  = 1'b1;
      step_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      vld_q  <= 1'b0;
      step_q <= 3'd0;
    end else begin
      busy_q <= busy_d;
      vld_q  <= vld_d;
      step_q <= step_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      neg_q <= clamped[16];
      bin_q <= clamped[15:0];
      mag_q <= mag_ld;
    end else if (busy_q) begin
      mag_q         <= mag_d;
      dig_q[step_q] <= digit;
    end
  end

  // Left-aligned decimal string without leading zeros
  logic [2:0] first;
  logic [3:0] pos;

  always_comb begin
    first = 3'(NUM_DIGITS - 1);
    for (int j = NUM_DIGITS - 2; j >= 0; j--) begin
      if (dig_q[j] != 4'd0) begin
        first = 3'(j);
      end
    end
    res_o.neg = neg_q;
    res_o.bin = bin_q;
    res_o.len = 3'(NUM_DIGITS) - first + {2'b00, neg_q};
    for (int k = 0; k < STR_MAX; k++) begin
      pos = {1'b0, first} + 4'(k) - {3'b000, neg_q};
      if (neg_q && (k == 0)) begin
        res_o.str[k] = CHR_MINUS;
      end else if (pos < 4'(NUM_DIGITS)) begin
        res_o.str[k] = CHR_ZERO + {4'b0000, dig_q[pos[2:0]]};
      end else begin
        res_o.str[k] = 8'h00;
      end
    end
  end

  assign done_o = vld_q && !busy_q;

endmodule

// File: src/dcf_framer.sv
module dcf_framer
  import dcf_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  logic          stop_i,
  input  logic          text_i,
  input  dcf_lane_res_t axial_i,
  input  dcf_lane_res_t yaw_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o
);

  localparam logic [1:0] KIND_STOP = 2'd0;
  localparam logic [1:0] KIND_BIN  = 2'd1;
  localparam logic [1:0] KIND_TEXT = 2'd2;
  localparam int         BUF_LEN   = 16;

  logic        act_q, act_d;
  logic [1:0]  kind_q, kind_d;
  logic [4:0]  len_q, len_d;
  logic [3:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  buf_q [BUF_LEN];
  logic [7:0]  buf_d [BUF_LEN];
  logic        out_vld_q, out_vld_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;

  logic       adv, is_last;
  logic [7:0] cur_byte;

  // Merge lane results into a frame image
  logic [4:0] p, oa, oy;

  always_comb begin
    p  = 5'd0;
    oa = 5'd0;
    oy = 5'd0;
    for (int i = 0; i < BUF_LEN; i++) begin
      buf_d[i] = 8'h00;
    end
    if (stop_i) begin
      kind_d   = KIND_STOP;
      len_d    = 5'd8;
      buf_d[0] = CHR_SLASH;
      buf_d[3] = STOP_CMD;
      buf_d[7] = CHR_NL;
    end else if (!text_i) begin
      kind_d    = KIND_BIN;
      len_d     = 5'd12;
      buf_d[0]  = CHR_SLASH;
      buf_d[1]  = SPEED_LEN_FIELD;
      buf_d[3]  = SPEED_CMD;
      buf_d[5]  = axial_i.bin[7:0];
      buf_d[6]  = axial_i.bin[15:8];
      buf_d[7]  = yaw_i.bin[7:0];
      buf_d[8]  = yaw_i.bin[15:8];
      buf_d[11] = CHR_NL;
    end else begin
      kind_d = KIND_TEXT;
      len_d  = 5'd4 + {2'b00, axial_i.len} + {2'b00, yaw_i.len};
      for (int i = 0; i < BUF_LEN; i++) begin
        p  = 5'(i);
        oa = p - 5'd2;
        oy = p - 5'd3 - {2'b00, axial_i.len};
        if (p == 5'd0) begin
          buf_d[i] = CHR_GT;
        end else if (p == 5'd1) begin
          buf_d[i] = CHR_SP;
        end else if (oa < {2'b00, axial_i.len}) begin
          buf_d[i] = axial_i.str[oa[2:0]];
        end else if (oy == 5'h1F) begin
          buf_d[i] = CHR_COMMA;
        end else if (oy < {2'b00, yaw_i.len}) begin
          buf_d[i] = yaw_i.str[oy[2:0]];
        end else if (oy == {2'b00, yaw_i.len}) begin
          buf_d[i] = CHR_NL;
        end else begin
          buf_d[i] = 8'h00;
        end
      end
    end
  end

  // Byte selection, with the running CRC in its two slots
  always_comb begin
    if ((kind_q != KIND_TEXT) && ({1'b0, idx_q} == len_q - 5'd3)) begin
      cur_byte = crc_q[7:0];
    end else if ((kind_q != KIND_TEXT) && ({1'b0, idx_q} == len_q - 5'd2)) begin
      cur_byte = crc_q[15:8];
    end else begin
      cur_byte = buf_q[idx_q];
    end
    is_last = ({1'b0, idx_q} == len_q - 5'd1);
  end

  assign adv    = !out_vld_q || out_ready_i;
  assign free_o = !act_q || (adv && is_last);

  // Sequencing and output register
  always_comb begin
    act_d      = act_q;
    idx_d      = idx_q;
    crc_d      = crc_q;
    out_vld_d  = out_vld_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    if (adv) begin
      out_vld_d = act_q;
      if (act_q) begin
        out_byte_d = cur_byte;
        out_last_d = is_last;
        // CRC covers the message bytes only and holds while its own bytes go out
        if ({1'b0, idx_q} < len_q - 5'd3) begin
          crc_d = crc_byte(crc_q, cur_byte);
        end
        idx_d      = idx_q + 4'd1;
        if (is_last) begin
          act_d = 1'b0;
        end
      end
    end
    if (load_i && free_o) begin
      act_d = 1'b1;
      idx_d = 4'd0;
      crc_d = 16'h0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      act_q     <= act_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    crc_q      <= crc_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    if (load_i && free_o) begin
      kind_q <= kind_d;
      len_q  <= len_d;
      for (int i = 0; i < BUF_LEN; i++) begin
        buf_q[i] <= buf_d[i];
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

// File: src/drive_command_framer.sv
// Drive command framer.
// Input stream: one transaction per request. tuser carries the kind (0 speed,
// 1 emergency stop); tdata carries axial in bits 15:0 and yaw in bits 31:16.
// Output stream: one byte per transaction, tlast on the final byte of a frame.
// Binary speed frames are 12 bytes, stop frames 8 bytes, text lines 6 to 16.
// APB port: text_mode at 0x0, speed_limit at 0x4, yaw_limit at 0x8.
// Two lanes clamp axial and yaw and extract five decimal digits, one per
// cycle; the framer then sends one byte per cycle while the receiver accepts,
// with the CRC computed as bytes go out. A new request is accepted once the
// lanes hand the previous one to the framer, so it is converted while the
// framer still sends the previous frame.
// Reset clears the pipeline and loads text_mode 0 and both limits to 5000.
// When the receiver stalls, the output register holds its byte; the lanes
// keep one finished request waiting and the input side then deasserts tready.
module drive_command_framer
  import dcf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] axial, [31:16] yaw
  input  logic        s_axis_tuser,  // [0] op
  // byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] frame_byte
  output logic        m_axis_tlast,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_TEXT_MODE   = 2'd0;
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd1;
  localparam logic [1:0] REG_YAW_LIMIT   = 2'd2;

  logic        text_mode_q;
  logic [14:0] speed_limit_q, yaw_limit_q;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_mode_q   <= 1'b0;
      speed_limit_q <= 15'd5000;
      yaw_limit_q   <= 15'd5000;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TEXT_MODE:   text_mode_q   <= pwdata[0];
        REG_SPEED_LIMIT: speed_limit_q <= pwdata[14:0];
        REG_YAW_LIMIT:   yaw_limit_q   <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEXT_MODE:   prdata = {31'b0, text_mode_q};
      REG_SPEED_LIMIT: prdata = {17'b0, speed_limit_q};
      REG_YAW_LIMIT:   prdata = {17'b0, yaw_limit_q};
      default:         prdata = 32'h0;
    endcase
  end

  // Lane stage
  logic          in_acc, take, frm_free;
  logic          ax_done, yw_done, lane_vld_q;
  logic          op_q;
  dcf_lane_res_t ax_res, yw_res;

  assign take          = ax_done && yw_done && frm_free;
  assign s_axis_tready = !lane_vld_q || take;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_vld_q <= 1'b0;
    end else if (in_acc) begin
      lane_vld_q <= 1'b1;
    end else if (take) begin
      lane_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= s_axis_tuser;
    end
  end

  dcf_lane u_lane_axial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_acc),
    .take_i  (take),
    .raw_i   (s_axis_tdata[15:0]),
    .limit_i (speed_limit_q),
    .done_o  (ax_done),
    .res_o   (ax_res)
  );

  dcf_lane u_lane_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_acc),
    .take_i  (take),
    .raw_i   (s_axis_tdata[31:16]),
    .limit_i (yaw_limit_q),
    .done_o  (yw_done),
    .res_o   (yw_res)
  );

  // Merge and serialize
  dcf_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .stop_i      (op_q),
    .text_i      (text_mode_q),
    .axial_i     (ax_res),
    .yaw_i       (yw_res),
    .free_o      (frm_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // Checks
  a_lanes_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ax_done == yw_done)
    else $error("lanes finished out of step");

  a_frame_ends_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == CHR_NL))
    else $error("frame does not end in newline");

  a_lanes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("request taken while lanes still converting");

endmodule

// File: tb/sv/drive_command_framer_tb.sv
`timescale 1ns / 1ps

module drive_command_framer_tb
  import dcf_pkg::*;
;

  localparam int CLK_PERIOD     = 10;
  localparam int IDLE_LIMIT     = 3000;  // cycles without any transaction
  localparam int DRAIN_CYCLES   = 24;    // first byte latency plus margin
  localparam int HOLD_CYCLES    = 200;
  localparam int HOLD_AT_REQ    = 70;
  localparam int RANDOM_PHASES  = 4;
  localparam int REQS_PER_PHASE = 28;

  typedef enum logic [3:0] {
    REG_TEXT_MODE   = 4'h0,
    REG_SPEED_LIMIT = 4'h4,
    REG_YAW_LIMIT   = 4'h8,
    REG_SPARE       = 4'hC
  } reg_addr_e;

  typedef enum bit {
    REQ_SPEED = 1'b0,
    REQ_STOP  = 1'b1
  } req_kind_e;

  typedef struct {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_beat_t;

  typedef logic [7:0] octet_q_t[$];

  // Directed row: register setting, request, and the text line where it is obvious
  typedef struct {
    bit          text_mode;
    int          speed_lim;
    int          yaw_lim;
    req_kind_e   kind;
    logic [15:0] axial;
    logic [15:0] yaw;
    string       line;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // [15:0] axial, [31:16] yaw
  logic        s_axis_tuser  = 1'b0;  // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // [7:0] frame_byte
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // Register shadow, matches reset
  bit          cfg_text      = 1'b0;
  logic [14:0] cfg_speed_lim = 15'd5000;
  logic [14:0] cfg_yaw_lim   = 15'd5000;

  frame_beat_t expected_bytes[$];
  frame_beat_t got_beat;
  int          error_count   = 0;
  int          accepted_reqs = 0;
  int          idle_cycles   = 0;
  int          burst_left    = 0;
  bit          offering      = 1'b0;

  dir_row_t dir_rows[18] = '{
    '{0, 5000, 5000, REQ_SPEED, 16'h0000, 16'h0000, ""},
    '{0, 5000, 5000, REQ_SPEED, 16'h7FFF, 16'h8000, ""},
    '{0, 5000, 5000, REQ_STOP, 16'hFFFF, 16'hFFFF, ""},
    '{0, 5000, 5000, REQ_SPEED, -16'sd5000, 16'sd5000, ""},
    '{0, 5000, 5000, REQ_SPEED, 16'sd5001, -16'sd5001, ""},
    '{0, 32767, 32767, REQ_SPEED, 16'h7FFF, 16'h8000, ""},
    '{0, 32767, 32767, REQ_SPEED, 16'hFFFF, 16'h0001, ""},
    '{0, 0, 0, REQ_SPEED, 16'sd1234, -16'sd1234, ""},
    '{0, 0, 0, REQ_STOP, 16'h0000, 16'h0000, ""},
    '{1, 32767, 32767, REQ_SPEED, 16'h8000, 16'h7FFF, "> -32767,32767\n"},
    '{1, 32767, 32767, REQ_SPEED, 16'sd10000, -16'sd100, "> 10000,-100\n"},
    '{1, 32767, 32767, REQ_SPEED, 16'h0000, 16'hFFFF, "> 0,-1\n"},
    '{1, 32767, 32767, REQ_STOP, 16'h1234, 16'h5678, ""},
    '{1, 32767, 32767, REQ_SPEED, 16'h8001, 16'h8000, "> -32767,-32767\n"},
    '{1, 0, 0, REQ_SPEED, 16'sd100, -16'sd100, "> 0,0\n"},
    '{1, 5000, 300, REQ_SPEED, 16'sd9999, -16'sd9999, "> 5000,-300\n"},
    '{1, 5000, 300, REQ_SPEED, 16'sd7, 16'sd40, "> 7,40\n"},
    '{0, 1, 32767, REQ_SPEED, -16'sd3, 16'sd20000, ""}
  };

  drive_command_framer i_dut (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] crc16_msb_first(octet_q_t msg);
    logic [15:0] acc;
    logic        fb;
    acc = '0;
    foreach (msg[i]) begin
      for (int b = 7; b >= 0; b--) begin
        fb  = acc[15] ^ msg[i][b];
        acc = {acc[14:0], 1'b0};
        if (fb) begin
          acc = acc ^ CRC_POLY;
        end
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] clamp_to(logic [15:0] raw, logic [14:0] lim);
    int v;
    int l;
    v = int'($signed(raw));
    l = int'(lim);
    if (v > l) begin
      v = l;
    end else if (v < -l) begin
      v = -l;
    end
    return v[15:0];
  endfunction

  function automatic void push_line(string s);
    foreach (s[i]) begin
      expected_bytes.push_back(frame_beat_t'{s[i], i == s.len() - 1});
    end
  endfunction

  function automatic void predict_frame(req_kind_e kind, logic [15:0] ax_raw,
                                        logic [15:0] yw_raw);
    logic signed [15:0] ax;
    logic signed [15:0] yw;
    octet_q_t           msg;
    logic [15:0]        crc;
    ax = clamp_to(ax_raw, cfg_speed_lim);
    yw = clamp_to(yw_raw, cfg_yaw_lim);
    if (kind == REQ_STOP) begin
      msg = '{CHR_SLASH, 8'h00, 8'h00, STOP_CMD, 8'h00};
    end else if (cfg_text) begin
      push_line($sformatf("> %0d,%0d\n", ax, yw));
      return;
    end else begin
      msg = '{CHR_SLASH, SPEED_LEN_FIELD, 8'h00, SPEED_CMD, 8'h00,
              ax[7:0], ax[15:8], yw[7:0], yw[15:8]};
    end
    crc = crc16_msb_first(msg);
    msg.push_back(crc[7:0]);
    msg.push_back(crc[15:8]);
    msg.push_back(CHR_NL);
    foreach (msg[i]) begin
      expected_bytes.push_back(frame_beat_t'{msg[i], i == msg.size() - 1});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  task automatic reg_write(reg_addr_e addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // register takes the value at this edge
    psel    <= 1'b0;
    penable <= 1'b0;
    case (addr)
      REG_TEXT_MODE:   cfg_text = value[0];
      REG_SPEED_LIMIT: cfg_speed_lim = value[14:0];
      REG_YAW_LIMIT:   cfg_yaw_lim = value[14:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic reg_check(reg_addr_e addr, logic [31:0] exp_val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== exp_val) begin
      $error("prdata[%s]: expected %h, got %h", addr.name(), exp_val, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Request sender
  // ---------------------------------------------------------------------------

  task automatic stop_offering();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Register writes only once every byte in flight has come out
  task automatic set_config(bit tm, int slim, int ylim);
    stop_offering();
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    // upper bits carry noise, the block must mask them
    reg_write(REG_TEXT_MODE, (32'($urandom()) << 1) | 32'(tm));
    reg_write(REG_SPEED_LIMIT, (32'($urandom()) << 15) | 32'(slim));
    reg_write(REG_YAW_LIMIT, (32'($urandom()) << 15) | 32'(ylim));
    reg_check(REG_TEXT_MODE, 32'(cfg_text));
    reg_check(REG_SPEED_LIMIT, 32'(cfg_speed_lim));
    reg_check(REG_YAW_LIMIT, 32'(cfg_yaw_lim));
  endtask

  // One request transaction, then the burst / gap decision
  task automatic offer_req(req_kind_e kind, logic [15:0] ax, logic [15:0] yw, string line);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {yw, ax};
    offering = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    accepted_reqs++;
    if (line.len() != 0) begin
      push_line(line);
    end else begin
      predict_frame(kind, ax, yw);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom();
      s_axis_tuser  <= $urandom_range(0, 1);
      offering = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Mix of full-range values, values around the clamp edges, and small ones
  function automatic logic [15:0] pick_value(int lim);
    int v;
    case ($urandom_range(0, 3))
      0, 1:    v = int'($urandom_range(0, 65535));
      2:       v = ($urandom_range(0, 1) ? lim : -lim) + int'($urandom_range(0, 4)) - 2;
      default: v = int'($urandom_range(0, 200)) - 100;
    endcase
    return v[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Byte receiver: segments of different stall patterns, one long hold-off
  // ---------------------------------------------------------------------------

  initial begin
    int seg_left;
    int mode;
    int hold_left;
    bit hold_done;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && accepted_reqs >= HOLD_AT_REQ) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 60);
        mode     = $urandom_range(0, 3);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= $urandom_range(0, 1);
          2:       m_axis_tready <= ($urandom_range(0, 4) != 0);
          default: m_axis_tready <= (seg_left % 3 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output check
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("frame_byte: expected none, got %h", m_axis_tdata);
        error_count++;
      end else begin
        got_beat = expected_bytes.pop_front();
        if (m_axis_tdata !== got_beat.frame_byte) begin
          $error("frame_byte: expected %h, got %h", got_beat.frame_byte, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tlast !== got_beat.last_byte) begin
          $error("last_byte: expected %b, got %b", got_beat.last_byte, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    req_kind_e kind;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values; a write to the unused address changes nothing
    reg_write(REG_SPARE, $urandom());
    reg_check(REG_TEXT_MODE, 32'd0);
    reg_check(REG_SPEED_LIMIT, 32'd5000);
    reg_check(REG_YAW_LIMIT, 32'd5000);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].text_mode != cfg_text || dir_rows[i].speed_lim != int'(cfg_speed_lim)
          || dir_rows[i].yaw_lim != int'(cfg_yaw_lim)) begin
        set_config(dir_rows[i].text_mode, dir_rows[i].speed_lim, dir_rows[i].yaw_lim);
      end
      offer_req(dir_rows[i].kind, dir_rows[i].axial, dir_rows[i].yaw, dir_rows[i].line);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       set_config(1'b0, $urandom_range(0, 32767), $urandom_range(0, 32767));
        1:       set_config(1'b1, 32767, 32767);
        2:       set_config(1'b1, $urandom_range(0, 12000), $urandom_range(0, 12000));
        default: set_config(1'b0, $urandom_range(1, 600), 32767);
      endcase
      repeat (REQS_PER_PHASE) begin
        kind = ($urandom_range(0, 4) == 0) ? REQ_STOP : REQ_SPEED;
        offer_req(kind, pick_value(cfg_speed_lim), pick_value(cfg_yaw_lim), "");
      end
    end

    stop_offering();
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
src/dcf_pkg.sv
src/dcf_lane.sv
src/dcf_framer.sv
src/drive_command_framer.sv
tb/sv/drive_command_framer_tb.sv
